/* design/bsf_soc_pkg.sv */
// ----------------------------------------------------------------------------
// Battery sample filter package
// Widths, the charge table and the divider control types shared by the design.
// ----------------------------------------------------------------------------
package bsf_soc_pkg;

   localparam int SAMPLE_W             = 12;
   localparam int PCT_W                = 7;
   localparam int MV_W                 = 16;
   localparam int RATIO_W              = 16;
   localparam int REQ_DATA_W           = 16;
   localparam int RSP_DATA_W           = 40;
   localparam int WINDOW_DEPTH_DEFAULT = 8;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd2048;
   localparam logic [MV_W-1:0]    MV_SAT      = 16'hFFFF;
   localparam logic [PCT_W-1:0]   PCT_TOP     = 7'd100;
   localparam logic [PCT_W-1:0]   PCT_BOTTOM  = 7'd0;

   // millivolts = filtered * MV_SCALE / (ADC_FULL * ratio)
   localparam longint MV_SCALE = 3600 * 4096;
   localparam int     ADC_FULL = 4095;

   // shared divider sizing
   localparam int NUM_W  = 36;
   localparam int DEN_W  = 28;
   localparam int QUO_W  = 16;
   localparam int ITER_W = $clog2(QUO_W + 1);
   localparam int DSH_W  = DEN_W + QUO_W - 1;

   localparam logic [ITER_W-1:0] ITER_INTERP = ITER_W'(PCT_W);
   localparam logic [ITER_W-1:0] ITER_MV     = ITER_W'(QUO_W);

   // charge table, descending level
   localparam int TABLE_POINTS = 13;
   localparam int IDX_W        = $clog2(TABLE_POINTS);

   localparam logic [SAMPLE_W-1:0] SOC_LEVEL [TABLE_POINTS] = '{
      12'd557, 12'd540, 12'd525, 12'd510, 12'd495, 12'd480, 12'd465,
      12'd460, 12'd445, 12'd430, 12'd420, 12'd412, 12'd408
   };

   localparam logic [PCT_W-1:0] SOC_PCT [TABLE_POINTS] = '{
      7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
      7'd40,  7'd30, 7'd20, 7'd10, 7'd5,  7'd0
   };

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
      logic [ITER_W-1:0] iters;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUO_W-1:0]  quotient;
   } div_rsp_type;

endpackage

/* design/battery_sample_filter_soc_estimator.sv */
// A primed window's result holds an interpolated charge and a divided millivolt value;
// a table end or flat segment skips the first division, a saturated reading the second.
// The first sample after reset is written to every window slot. One sample at a time goes
// through the shared bit-serial divider (7 and 16 quotient bits), so the next is taken once
// the result is registered, later while a result is held. Synchronous active-high reset
// clears sequencer, slot, primed and output valid flags, and sets the ratio to 2048.
// ----------------------------------------------------------------------------
// Battery sample filter and state-of-charge estimator
// Moving average, piecewise linear charge lookup and millivolt conversion.
// ----------------------------------------------------------------------------
module battery_sample_filter_soc_estimator #(
   parameter int WINDOW_DEPTH = bsf_soc_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [11:0] adc_sample, [15:12] zero
   input  logic [bsf_soc_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] filtered_sample, [18:12] charge_percent, [34:19] battery_millivolts,
   // [39:35] zero
   output logic [bsf_soc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bsf_soc_pkg::RATIO_W-1:0]     csr_data
);
   import bsf_soc_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = $clog2(4096 * WINDOW_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

   // mean by reciprocal multiplication, exact for every window sum
   localparam int MEAN_L  = $clog2(WINDOW_DEPTH);
   localparam int MEAN_K  = SUM_W + MEAN_L;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(
      ((64'd1 << MEAN_K) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FILL   = 4'd1;
   localparam logic [3:0] S_READ   = 4'd2;
   localparam logic [3:0] S_UPD    = 4'd3;
   localparam logic [3:0] S_MEAN   = 4'd4;
   localparam logic [3:0] S_SEG    = 4'd6;
   localparam logic [3:0] S_PROD   = 4'd7;
   localparam logic [3:0] S_INT_W  = 4'd8;
   localparam logic [3:0] S_MV     = 4'd9;
   localparam logic [3:0] S_MV_W   = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                primed_ff, primed_in;
   logic [RATIO_W-1:0]  ratio_ff;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] filt_ff, filt_in;
   logic [IDX_W-1:0]    seg_ff, seg_in;
   logic                below_ff, below_in;
   logic                top_ff, top_in;
   logic [PCT_W-1:0]    pl_ff, pl_in;
   logic [PCT_W-1:0]    pct_ff, pct_in;
   logic [NUM_W-1:0]    mv_num_ff, mv_num_in;
   logic [DEN_W-1:0]    mv_den_ff, mv_den_in;
   logic [MV_W-1:0]     mv_ff, mv_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SAMPLE_W-1:0] window_mem [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                mem_we;

   logic [IDX_W-1:0]    seg_next;
   logic [SAMPLE_W-1:0] lvl_hi, lvl_lo;
   logic [PCT_W-1:0]    pct_hi, pct_lo;
   logic [IDX_W-1:0]    seg_comb;
   logic                seg_found;
   logic                mv_sat;
   logic [PROD_W-1:0]   mean_prod;

   div_req_type div_req;
   div_rsp_type div_rsp;

   bsf_soc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign seg_next  = IDX_W'(seg_ff + 1'b1);
   assign lvl_hi    = SOC_LEVEL[seg_ff];
   assign lvl_lo    = SOC_LEVEL[seg_next];
   assign pct_hi    = SOC_PCT[seg_ff];
   assign pct_lo    = SOC_PCT[seg_next];
   assign mv_sat    = (ratio_ff == '0) ||
                      ((DEN_W + QUO_W)'(mv_num_ff) >= {mv_den_ff, {QUO_W{1'b0}}});
   assign mean_prod = PROD_W'(sum_ff) * PROD_W'(MEAN_RECIP);

   always_comb begin
      seg_comb  = '0;
      seg_found = 1'b0;
      for (int j = 1; j < TABLE_POINTS; j++) begin
         if (!seg_found && (filt_ff >= SOC_LEVEL[j])) begin
            seg_comb  = IDX_W'(j - 1);
            seg_found = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      primed_in    = primed_ff;
      sample_in    = sample_ff;
      sum_in       = sum_ff;
      filt_in      = filt_ff;
      seg_in       = seg_ff;
      below_in     = below_ff;
      top_in       = top_ff;
      pl_in        = pl_ff;
      pct_in       = pct_ff;
      mv_num_in    = mv_num_ff;
      mv_den_in    = mv_den_ff;
      mv_in        = mv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      div_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[SAMPLE_W-1:0];
               if (primed_ff) begin
                  state_in = S_READ;
               end else begin
                  sum_in   = '0;
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            mem_we = 1'b1;
            sum_in = sum_ff + SUM_W'(sample_ff);
            if (slot_ff == SLOT_LAST) begin
               slot_in   = SLOT_W'(1);
               primed_in = 1'b1;
               state_in  = S_MEAN;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         S_READ: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            mem_we   = 1'b1;
            sum_in   = sum_ff - SUM_W'(rd_data_ff) + SUM_W'(sample_ff);
            slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            state_in = S_MEAN;
         end
         S_MEAN: begin
            filt_in  = mean_prod[MEAN_K +: SAMPLE_W];
            state_in = S_SEG;
         end
         S_SEG: begin
            seg_in    = seg_comb;
            below_in  = filt_ff < SOC_LEVEL[TABLE_POINTS-1];
            top_in    = filt_ff >= SOC_LEVEL[0];
            mv_num_in = NUM_W'(filt_ff) * NUM_W'(MV_SCALE);
            mv_den_in = DEN_W'({ratio_ff, 12'b0}) - DEN_W'(ratio_ff);
            state_in  = S_PROD;
         end
         S_PROD: begin
            pl_in = pct_lo;
            if (below_ff) begin
               pct_in   = PCT_BOTTOM;
               state_in = S_MV;
            end else if (top_ff) begin
               pct_in   = PCT_TOP;
               state_in = S_MV;
            end else if ((lvl_hi == lvl_lo) || (pct_hi < pct_lo)) begin
               pct_in   = pct_lo;
               state_in = S_MV;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = NUM_W'(SAMPLE_W'(filt_ff - lvl_lo)) *
                               NUM_W'(PCT_W'(pct_hi - pct_lo));
               div_req.den   = DEN_W'(SAMPLE_W'(lvl_hi - lvl_lo));
               div_req.iters = ITER_INTERP;
               state_in      = S_INT_W;
            end
         end
         S_INT_W: begin
            if (div_rsp.done) begin
               pct_in   = PCT_W'(pl_ff + div_rsp.quotient[PCT_W-1:0]);
               state_in = S_MV;
            end
         end
         S_MV: begin
            if (mv_sat) begin
               mv_in    = MV_SAT;
               state_in = S_OUT;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = mv_num_ff;
               div_req.den   = mv_den_ff;
               div_req.iters = ITER_MV;
               state_in      = S_MV_W;
            end
         end
         S_MV_W: begin
            if (div_rsp.done) begin
               mv_in    = div_rsp.quotient[MV_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_DATA_W - MV_W - PCT_W - SAMPLE_W)'(0),
                               mv_ff, pct_ff, filt_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         primed_ff    <= 1'b0;
         ratio_ff     <= RATIO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            ratio_ff <= csr_data;
         end
      end
      sample_ff   <= sample_in;
      sum_ff      <= sum_in;
      filt_ff     <= filt_in;
      seg_ff      <= seg_in;
      below_ff    <= below_in;
      top_ff      <= top_in;
      pl_ff       <= pl_in;
      pct_ff      <= pct_in;
      mv_num_ff   <= mv_num_in;
      mv_den_ff   <= mv_den_in;
      mv_ff       <= mv_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[slot_ff] <= sample_ff;
      end
      rd_data_ff <= window_mem[slot_ff];
   end

endmodule

/* design/bsf_soc_divider.sv */
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle, iteration count set per request.
// ----------------------------------------------------------------------------
module bsf_soc_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  bsf_soc_pkg::div_req_type div_req,
   output bsf_soc_pkg::div_rsp_type div_rsp
);
   import bsf_soc_pkg::*;

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DSH_W-1:0]  dsh_ff, dsh_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              take;

   assign take = DSH_W'(rem_ff) >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.num;
         dsh_in  = DSH_W'(div_req.den) << (div_req.iters - 1'b1);
         quo_in  = '0;
         cnt_in  = div_req.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (take) begin
            rem_in = rem_ff - dsh_ff[NUM_W-1:0];
         end
         quo_in = {quo_ff[QUO_W-2:0], take};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* design/bsf_soc_checker.sv */
// ----------------------------------------------------------------------------
// Battery sample filter port checker
// Port-level properties of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module bsf_soc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bsf_soc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result transaction changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while previous sample in progress");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:12] <= 7'd100)
      else $error("charge percent above 100");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:35] == 5'd0)
      else $error("result padding not zero");

endmodule

bind battery_sample_filter_soc_estimator bsf_soc_checker u_bsf_soc_checker (.*);
